@@ rtl/bfm_pkg.sv @@
// shared types and constants for the mod-prime bloom filter core
// used by bfm_ctrl, bfm_modred and bloom_filter_modprime_core
package bfm_pkg;

  localparam int unsigned NUM_TABLES_DEF      = 8;
  localparam int unsigned WORDS_PER_TABLE_DEF = 1250;
  localparam int unsigned MAX_TABLES          = 8;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned IDX_W  = 14;
  localparam int unsigned WORD_W = 64;

  // remainder width: every prime is below 2**17
  localparam int unsigned RES_W      = 17;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned HASH_STEPS = KEY_W / NIB_W;
  localparam int unsigned BIT_W      = 6;

  localparam logic [RES_W-1:0] PRIMES [MAX_TABLES] = '{
    RES_W'(79559), RES_W'(79631), RES_W'(79691), RES_W'(79697),
    RES_W'(79811), RES_W'(79841), RES_W'(79901), RES_W'(79997)
  };

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_MERGE  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic clearing;
    logic hash_step;
    logic rd_en;
    logic update;
    logic load_out;
    op_t  op;
  } ctl_t;

endpackage

@@ rtl/bfm_bank.sv @@
// one table of the filter: single-port synchronous ram, registered read
// no package dependency
module bfm_bank #(
  parameter int unsigned DEPTH = 1250,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/bfm_modred.sv @@
// key modulo a fixed prime, four key bits per step, msb first
// depends on bfm_pkg
module bfm_modred #(
  parameter logic [bfm_pkg::RES_W-1:0] PRIME = bfm_pkg::PRIMES[0]
) (
  input  logic                      clk,
  input  logic                      start,
  input  logic                      step,
  input  logic [bfm_pkg::NIB_W-1:0] nib,
  output logic [bfm_pkg::RES_W-1:0] rem
);
  import bfm_pkg::*;

  localparam int unsigned XW = RES_W + NIB_W;

  logic [XW-1:0]    x;
  logic [RES_W-1:0] rem_next;

  // rem < prime, so rem*16 + nib < 16*prime: one conditional subtract per bit
  always_comb begin
    x = {rem, nib};
    for (int i = NIB_W - 1; i >= 0; i--) begin
      if (x >= (XW'(PRIME) << i)) begin
        x = x - (XW'(PRIME) << i);
      end
    end
    rem_next = RES_W'(x);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
    end else if (step) begin
      rem <= rem_next;
    end
  end

endmodule

@@ rtl/bfm_ctrl.sv @@
// sequencer: clearing pass, hash steps, bank read and read-modify-write
// depends on bfm_pkg
module bfm_ctrl #(
  parameter int unsigned WORDS_PER_TABLE = bfm_pkg::WORDS_PER_TABLE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic [bfm_pkg::OP_W-1:0]           op,
  input  logic                               out_valid,
  input  logic                               out_ready,
  output bfm_pkg::ctl_t                      ctl,
  output logic [$clog2(WORDS_PER_TABLE)-1:0] clr_addr
);
  import bfm_pkg::*;

  localparam int unsigned AW = $clog2(WORDS_PER_TABLE);
  localparam int unsigned CW = $clog2(HASH_STEPS);

  state_t         state, state_next;
  op_t            op_q;
  logic [CW-1:0]  hash_cnt;
  logic [AW-1:0]  clr_cnt;
  logic           accept;
  logic           slot_free;

  assign accept    = in_valid && (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign clr_addr  = clr_cnt;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(WORDS_PER_TABLE - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(op))
            OP_INSERT, OP_QUERY: state_next = ST_HASH;
            OP_MERGE:            state_next = ST_READ;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_HASH: begin
        if (hash_cnt == CW'(HASH_STEPS - 1)) state_next = ST_READ;
      end
      ST_READ: state_next = ST_UPDATE;
      ST_UPDATE: begin
        // a query waits here until the result register is free
        if (op_q != OP_QUERY || slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.op        = op_q;
    ctl.in_ready  = (state == ST_IDLE);
    ctl.clearing  = (state == ST_CLEAR);
    ctl.hash_step = (state == ST_HASH);
    ctl.rd_en     = (state == ST_READ);
    ctl.update    = (state == ST_UPDATE) && (op_q != OP_QUERY || slot_free);
    ctl.load_out  = ctl.update && (op_q == OP_QUERY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      hash_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (accept) begin
        hash_cnt <= '0;
      end else if (state == ST_HASH) begin
        hash_cnt <= hash_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) op_q <= op_t'(op);
  end

endmodule

@@ rtl/bloom_filter_modprime_core.sv @@
// Bloom filter with one bit table per prime; each key hashes to key mod prime.
// An insert or query runs as the input transfer, nibble-serial modular
// reduction (all tables in parallel), one bank read and one read-modify-write
// or result step; a query holds in the result step until the result register
// is free. A merge runs as decode, read and write back; an unused op code is
// accepted and dropped. After reset the banks are zeroed by a clearing pass
// over every word, during which in_ready stays low. Operations run one at a
// time, so a write back is always committed before the next read of any bank.
// depends on bfm_pkg, bfm_ctrl, bfm_modred and bfm_bank
module bloom_filter_modprime_core #(
  parameter int unsigned NUM_TABLES      = bfm_pkg::NUM_TABLES_DEF,
  parameter int unsigned WORDS_PER_TABLE = bfm_pkg::WORDS_PER_TABLE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bfm_pkg::OP_W-1:0]   op,
  input  logic [bfm_pkg::KEY_W-1:0]  key,
  input  logic [bfm_pkg::IDX_W-1:0]  merge_index,
  input  logic [bfm_pkg::WORD_W-1:0] merge_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       found
);
  import bfm_pkg::*;

  localparam int unsigned AW = $clog2(WORDS_PER_TABLE);
  localparam int unsigned TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned CW = $clog2(NUM_TABLES * WORDS_PER_TABLE + 1);
  localparam int unsigned EW = (CW > IDX_W) ? CW : IDX_W;

  ctl_t                  ctl;
  logic [AW-1:0]         clr_addr;
  logic                  accept;
  logic [KEY_W-1:0]      key_sr;
  logic [NUM_TABLES-1:0] bank_we;
  logic [NUM_TABLES-1:0] hit_bits;

  // merge target, decoded at the input transfer
  logic [EW-1:0]     midx;
  logic [EW-1:0]     mbase;
  logic [TW-1:0]     msel;
  logic [TW-1:0]     m_tab;
  logic [AW-1:0]     m_word;
  logic              m_ok;
  logic [WORD_W-1:0] m_data;

  assign accept   = in_valid && ctl.in_ready;
  assign in_ready = ctl.in_ready;

  bfm_ctrl #(
    .WORDS_PER_TABLE(WORDS_PER_TABLE)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctl      (ctl),
    .clr_addr (clr_addr)
  );

  // table select by independent compares against each table's base word
  always_comb begin
    midx  = EW'(merge_index);
    msel  = '0;
    mbase = '0;
    for (int t = 1; t < NUM_TABLES; t++) begin
      if (midx >= EW'(t * WORDS_PER_TABLE)) begin
        msel  = TW'(t);
        mbase = EW'(t * WORDS_PER_TABLE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tab  <= msel;
      m_word <= AW'(midx - mbase);
      m_ok   <= midx < EW'(NUM_TABLES * WORDS_PER_TABLE);
      m_data <= merge_word;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_sr <= key;
    end else if (ctl.hash_step) begin
      key_sr <= key_sr << NIB_W;
    end
  end

  for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tab
    logic [RES_W-1:0]  rem;
    logic [AW-1:0]     addr;
    logic [BIT_W-1:0]  bsel;
    logic              inr;
    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] wdata;

    bfm_modred #(
      .PRIME(PRIMES[t])
    ) u_red (
      .clk  (clk),
      .start(accept),
      .step (ctl.hash_step),
      .nib  (key_sr[KEY_W-1 -: NIB_W]),
      .rem  (rem)
    );

    assign bsel = rem[BIT_W-1:0];
    assign inr  = (rem >> BIT_W) < RES_W'(WORDS_PER_TABLE);

    always_comb begin
      if (ctl.clearing) begin
        addr = clr_addr;
      end else if (ctl.op == OP_MERGE) begin
        addr = m_word;
      end else begin
        addr = AW'(rem >> BIT_W);
      end
    end

    assign bank_we[t] = ctl.clearing ||
                        (ctl.update && ((ctl.op == OP_INSERT && inr) ||
                         (ctl.op == OP_MERGE && m_ok && m_tab == TW'(t))));

    assign wdata = ctl.clearing ? '0 :
                   (ctl.op == OP_MERGE) ? (rdata | m_data) :
                   (rdata | (WORD_W'(1) << bsel));

    assign hit_bits[t] = inr && rdata[bsel];

    bfm_bank #(
      .DEPTH(WORDS_PER_TABLE),
      .WIDTH(WORD_W)
    ) u_bank (
      .clk  (clk),
      .rd_en(ctl.rd_en),
      .wr_en(bank_we[t]),
      .addr (addr),
      .wdata(wdata),
      .rdata(rdata)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) found <= &hit_bits;
  end

  // banks are written only by the clearing pass or a write back
  a_we_phase: assert property (@(posedge clk) disable iff (rst)
    !(ctl.update || ctl.clearing) |-> bank_we == '0)
    else $error("bank written outside clear or update");

  // a merge touches at most one table
  a_merge_onehot: assert property (@(posedge clk) disable iff (rst)
    (ctl.update && ctl.op == OP_MERGE) |-> $onehot0(bank_we))
    else $error("merge wrote more than one bank");

  // a query result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten");

endmodule
